// File: rtl/chip8_pkg.sv
// ----------------------------------------------------------------------------
// chip8_pkg
// Shared types and constants for the chip8 instruction core.
// ----------------------------------------------------------------------------
package chip8_pkg;

    localparam logic [11:0] PC_START   = 12'h200;
    localparam logic [11:0] FONT_BASE  = 12'h050;
    localparam int          FONT_BYTES = 80;

    localparam logic [15:0] OP_CLS   = 16'h00E0;
    localparam logic [15:0] OP_RET   = 16'h00EE;
    localparam logic [7:0]  NN_SKP   = 8'h9E;
    localparam logic [7:0]  NN_SKNP  = 8'hA1;
    localparam logic [7:0]  NN_WAITK = 8'h0A;

    localparam logic [7:0] FONT [0:FONT_BYTES-1] = '{
        8'hF0, 8'h90, 8'h90, 8'h90, 8'hF0, 8'h20, 8'h60, 8'h20, 8'h20, 8'h70,
        8'hF0, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h10, 8'hF0, 8'h10, 8'hF0,
        8'h90, 8'h90, 8'hF0, 8'h10, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'h10, 8'hF0,
        8'hF0, 8'h80, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h10, 8'h20, 8'h40, 8'h40,
        8'hF0, 8'h90, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h90, 8'hF0, 8'h10, 8'hF0,
        8'hF0, 8'h90, 8'hF0, 8'h90, 8'h90, 8'hE0, 8'h90, 8'hE0, 8'h90, 8'hE0,
        8'hF0, 8'h80, 8'h80, 8'h80, 8'hF0, 8'hE0, 8'h90, 8'h90, 8'h90, 8'hE0,
        8'hF0, 8'h80, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h80, 8'hF0, 8'h80, 8'h80
    };

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_FETCH_LO,
        S_DECODE,
        S_READ_VY,
        S_EXEC,
        S_FLAG,
        S_WAIT,
        S_ROW_RD,
        S_ROW_CAP
    } t_state;

endpackage

// File: rtl/chip8_ram.sv
// ----------------------------------------------------------------------------
// chip8_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module chip8_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [0:DEPTH-1];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/chip8_instruction_core.sv
// ----------------------------------------------------------------------------
// chip8_instruction_core
// CHIP-8 interpreter core: memory loads, instruction execution, sprite rows.
// ----------------------------------------------------------------------------
// After reset the core clears main memory and loads the font at 0x50,
// with stall held high. A write word then writes memory in the idle
// state and passes through the flag state to the hand-off of its result.
// An execute word goes through two fetch reads of the single read port
// of main memory, reads of Vx and Vy from the register file RAM, execute,
// flag write-back and the result. A DXYN with N rows does one main memory
// read, capture and hand-off per sprite row in place of those last two.
// One word is in flight at a time; stall is low only while the core is idle.
module chip8_instruction_core #(
    parameter int STACK_DEPTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_operation,
    input  logic [11:0] i_address,
    input  logic [7:0]  i_data,
    input  logic [15:0] i_key_state,
    input  logic [7:0]  i_random_byte,
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_is_row,
    output logic [7:0]  o_row_bits,
    output logic [7:0]  o_row_x,
    output logic [8:0]  o_row_y,
    output logic        o_clear_screen,
    output logic        o_waiting_key,
    output logic        o_unknown_opcode,
    output logic [11:0] o_program_counter,
    output logic        o_last
);
    import chip8_pkg::*;

    localparam int SP_W = $clog2(STACK_DEPTH);
    localparam logic [SP_W-1:0] SP_TOP = SP_W'(STACK_DEPTH - 1);

    t_state r_state, n_state;

    logic [11:0] r_clr, n_clr;
    logic [11:0] r_pc, n_pc;
    logic [11:0] r_i, n_i;
    logic [SP_W-1:0] r_sp, n_sp;
    logic [11:0] r_stack [0:STACK_DEPTH-1];
    logic [7:0]  r_hi, n_hi;
    logic [15:0] r_op, n_op;
    logic [7:0]  r_vx, n_vx;
    logic [7:0]  r_vy, n_vy;
    logic [15:0] r_keys, n_keys;
    logic [7:0]  r_rnd, n_rnd;
    logic [3:0]  r_h, n_h;
    logic        r_flag_we, n_flag_we;
    logic [7:0]  r_flag, n_flag;

    logic        r_out_valid, n_out_valid;
    logic        r_is_row, n_is_row;
    logic [7:0]  r_row_bits, n_row_bits;
    logic [7:0]  r_row_x, n_row_x;
    logic [8:0]  r_row_y, n_row_y;
    logic        r_clear, n_clear;
    logic        r_wait, n_wait;
    logic        r_unk, n_unk;
    logic        r_last, n_last;

    logic        stack_we;

    // main memory port
    logic        mem_we;
    logic [11:0] mem_waddr, mem_raddr;
    logic [7:0]  mem_wdata, mem_rdata;
    // register file port
    logic        v_we;
    logic [3:0]  v_waddr, v_raddr;
    logic [7:0]  v_wdata, v_rdata;

    logic [6:0]  font_idx;
    logic [8:0]  sum9;
    logic [3:0]  hi_key;
    logic [SP_W-1:0] sp_dec;

    chip8_ram #(.WIDTH(8), .DEPTH(4096)) u_mem (
        .i_clk  (i_clk),
        .i_we   (mem_we),
        .i_waddr(mem_waddr),
        .i_wdata(mem_wdata),
        .i_raddr(mem_raddr),
        .o_rdata(mem_rdata)
    );

    chip8_ram #(.WIDTH(8), .DEPTH(16)) u_vreg (
        .i_clk  (i_clk),
        .i_we   (v_we),
        .i_waddr(v_waddr),
        .i_wdata(v_wdata),
        .i_raddr(v_raddr),
        .o_rdata(v_rdata)
    );

    assign font_idx = 7'(r_clr - FONT_BASE);
    assign sp_dec   = (r_sp == '0) ? SP_TOP : r_sp - SP_W'(1);
    assign sum9     = {1'b0, r_vx} + {1'b0, v_rdata};

    // highest pressed key
    always_comb begin
        hi_key = 4'd0;
        for (int k = 0; k < 16; k++) begin
            if (r_keys[k]) begin
                hi_key = 4'(k);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_pc        <= PC_START;
            r_i         <= '0;
            r_sp        <= '0;
            r_out_valid <= 1'b0;
            r_flag_we   <= 1'b0;
            r_h         <= '0;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_pc        <= n_pc;
            r_i         <= n_i;
            r_sp        <= n_sp;
            r_out_valid <= n_out_valid;
            r_flag_we   <= n_flag_we;
            r_h         <= n_h;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < STACK_DEPTH; k++) begin
                r_stack[k] <= '0;
            end
        end else if (stack_we) begin
            r_stack[r_sp] <= r_pc;
        end
    end

    always_ff @(posedge i_clk) begin
        r_hi       <= n_hi;
        r_op       <= n_op;
        r_vx       <= n_vx;
        r_vy       <= n_vy;
        r_keys     <= n_keys;
        r_rnd      <= n_rnd;
        r_flag     <= n_flag;
        r_is_row   <= n_is_row;
        r_row_bits <= n_row_bits;
        r_row_x    <= n_row_x;
        r_row_y    <= n_row_y;
        r_clear    <= n_clear;
        r_wait     <= n_wait;
        r_unk      <= n_unk;
        r_last     <= n_last;
    end

    always_comb begin
        n_state     = r_state;
        n_clr       = r_clr;
        n_pc        = r_pc;
        n_i         = r_i;
        n_sp        = r_sp;
        n_hi        = r_hi;
        n_op        = r_op;
        n_vx        = r_vx;
        n_vy        = r_vy;
        n_keys      = r_keys;
        n_rnd       = r_rnd;
        n_h         = r_h;
        n_flag_we   = r_flag_we;
        n_flag      = r_flag;
        n_out_valid = r_out_valid;
        n_is_row    = r_is_row;
        n_row_bits  = r_row_bits;
        n_row_x     = r_row_x;
        n_row_y     = r_row_y;
        n_clear     = r_clear;
        n_wait      = r_wait;
        n_unk       = r_unk;
        n_last      = r_last;
        stack_we    = 1'b0;
        mem_we      = 1'b0;
        mem_waddr   = i_address;
        mem_wdata   = i_data;
        mem_raddr   = r_pc;
        v_we        = 1'b0;
        v_waddr     = r_op[11:8];
        v_wdata     = 8'd0;
        v_raddr     = r_hi[3:0];

        case (r_state)
            S_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = r_clr;
                mem_wdata = (r_clr >= FONT_BASE && r_clr < FONT_BASE + 12'(FONT_BYTES))
                            ? FONT[font_idx] : 8'd0;
                v_we      = (r_clr[11:4] == '0);
                v_waddr   = r_clr[3:0];
                n_clr     = r_clr + 12'd1;
                if (r_clr == 12'hFFF) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                // clear result fields for the non-row word
                n_is_row   = 1'b0;
                n_row_bits = 8'd0;
                n_row_x    = 8'd0;
                n_row_y    = 9'd0;
                n_clear    = 1'b0;
                n_wait     = 1'b0;
                n_unk      = 1'b0;
                n_last     = 1'b1;
                n_flag_we  = 1'b0;
                n_keys     = i_key_state;
                n_rnd      = i_random_byte;
                mem_raddr  = r_pc;
                if (i_valid) begin
                    if (!i_operation) begin
                        mem_we  = 1'b1;
                        n_state = S_FLAG;
                    end else begin
                        n_state = S_FETCH_LO;
                    end
                end
            end
            S_FETCH_LO: begin
                n_hi      = mem_rdata;
                mem_raddr = r_pc + 12'd1;
                n_pc      = r_pc + 12'd2;
                n_state   = S_DECODE;
            end
            S_DECODE: begin
                n_op    = {r_hi, mem_rdata};
                v_raddr = r_hi[3:0];
                n_state = S_READ_VY;
            end
            S_READ_VY: begin
                n_vx    = v_rdata;
                v_raddr = (r_op[15:12] == 4'hB) ? 4'd0 : r_op[7:4];
                n_state = S_EXEC;
            end
            S_EXEC: begin
                n_vy    = v_rdata;
                n_state = S_FLAG;
                case (r_op[15:12])
                    4'h0: begin
                        if (r_op == OP_CLS) begin
                            n_clear = 1'b1;
                        end else if (r_op == OP_RET) begin
                            n_sp = sp_dec;
                            n_pc = r_stack[sp_dec];
                        end else begin
                            n_unk = 1'b1;
                        end
                    end
                    4'h1: n_pc = r_op[11:0];
                    4'h2: begin
                        stack_we = 1'b1;
                        n_sp     = (r_sp == SP_TOP) ? '0 : r_sp + SP_W'(1);
                        n_pc     = r_op[11:0];
                    end
                    4'h3: if (r_vx == r_op[7:0]) n_pc = r_pc + 12'd2;
                    4'h4: if (r_vx != r_op[7:0]) n_pc = r_pc + 12'd2;
                    4'h5: if (r_vx == v_rdata) n_pc = r_pc + 12'd2;
                    4'h6: begin
                        v_we    = 1'b1;
                        v_wdata = r_op[7:0];
                    end
                    4'h7: begin
                        v_we    = 1'b1;
                        v_wdata = r_vx + r_op[7:0];
                    end
                    4'h8: begin
                        v_we = 1'b1;
                        case (r_op[3:0])
                            4'h0: v_wdata = v_rdata;
                            4'h1: v_wdata = r_vx | v_rdata;
                            4'h2: v_wdata = r_vx & v_rdata;
                            4'h3: v_wdata = r_vx ^ v_rdata;
                            4'h4: begin
                                v_wdata   = sum9[7:0];
                                n_flag_we = 1'b1;
                                n_flag    = {7'd0, sum9[8]};
                            end
                            4'h5: begin
                                v_wdata   = r_vx - v_rdata;
                                n_flag_we = 1'b1;
                                n_flag    = {7'd0, r_vx >= v_rdata};
                            end
                            4'h6: begin
                                v_wdata   = {1'b0, r_vx[7:1]};
                                n_flag_we = 1'b1;
                                n_flag    = {7'd0, r_vx[0]};
                            end
                            4'h7: begin
                                v_wdata   = v_rdata - r_vx;
                                n_flag_we = 1'b1;
                                n_flag    = {7'd0, v_rdata >= r_vx};
                            end
                            4'hE: begin
                                v_wdata   = {r_vx[6:0], 1'b0};
                                n_flag_we = 1'b1;
                                n_flag    = {7'd0, r_vx[7]};
                            end
                            default: begin
                                v_we  = 1'b0;
                                n_unk = 1'b1;
                            end
                        endcase
                    end
                    4'h9: if (r_vx != v_rdata) n_pc = r_pc + 12'd2;
                    4'hA: n_i = r_op[11:0];
                    4'hB: n_pc = r_op[11:0] + {4'd0, v_rdata};
                    4'hC: begin
                        v_we    = 1'b1;
                        v_wdata = r_rnd & r_op[7:0];
                    end
                    4'hD: begin
                        if (r_op[3:0] != 4'd0) begin
                            n_h     = 4'd0;
                            n_state = S_ROW_RD;
                        end
                    end
                    4'hE: begin
                        if (r_op[7:0] == NN_SKP) begin
                            if (r_keys[r_vx[3:0]]) n_pc = r_pc + 12'd2;
                        end else if (r_op[7:0] == NN_SKNP) begin
                            if (!r_keys[r_vx[3:0]]) n_pc = r_pc + 12'd2;
                        end else begin
                            n_unk = 1'b1;
                        end
                    end
                    default: begin
                        if (r_op[7:0] == NN_WAITK) begin
                            if (r_keys == 16'd0) begin
                                n_pc   = r_pc - 12'd2;
                                n_wait = 1'b1;
                            end else begin
                                v_we    = 1'b1;
                                v_wdata = {4'd0, hi_key};
                            end
                        end else begin
                            n_unk = 1'b1;
                        end
                    end
                endcase
            end
            S_FLAG: begin
                // flag lands after the result so vf wins when x is f
                v_we        = r_flag_we;
                v_waddr     = 4'hF;
                v_wdata     = r_flag;
                n_out_valid = 1'b1;
                n_state     = S_WAIT;
            end
            S_ROW_RD: begin
                mem_raddr = r_i + {8'd0, r_h};
                n_state   = S_ROW_CAP;
            end
            S_ROW_CAP: begin
                n_is_row    = 1'b1;
                n_row_bits  = mem_rdata;
                n_row_x     = r_vx;
                n_row_y     = {1'b0, r_vy} + {5'd0, r_h};
                n_last      = (r_h == r_op[3:0] - 4'd1);
                n_out_valid = 1'b1;
                n_state     = S_WAIT;
            end
            S_WAIT: begin
                if (!i_stall) begin
                    n_out_valid = 1'b0;
                    if (r_is_row && !r_last) begin
                        n_h     = r_h + 4'd1;
                        n_state = S_ROW_RD;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_stall           = (r_state != S_IDLE);
    assign o_valid           = r_out_valid;
    assign o_is_row          = r_is_row;
    assign o_row_bits        = r_row_bits;
    assign o_row_x           = r_row_x;
    assign o_row_y           = r_row_y;
    assign o_clear_screen    = r_clear;
    assign o_waiting_key     = r_wait;
    assign o_unknown_opcode  = r_unk;
    assign o_program_counter = r_pc;
    assign o_last            = r_last;

endmodule
